// ----- hdl/twa_pkg.sv -----
// Shared types and constants for the time window average block.
package twa_pkg;

  localparam int unsigned TIME_W       = 32;
  localparam int unsigned RATE_W       = 32;
  localparam int unsigned AVG_W        = 32;
  localparam int unsigned OUT_CNT_W    = 7;
  localparam int unsigned DIV_STEPS    = 32;
  localparam int unsigned STEP_W       = 5;
  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd300;

  // One classified sample as it travels from the front to the back.
  typedef struct packed {
    logic [TIME_W-1:0] sample_time;
    logic [RATE_W-1:0] sample_rate;
    logic [TIME_W-1:0] threshold;
  } item_t;

endpackage

// ----- hdl/twa_front.sv -----
// Front end: input handshake, window register and expiry threshold.
module twa_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [31:0]            sample_time_i,
  input  logic [31:0]            sample_rate_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [31:0]            window_seconds_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output twa_pkg::item_t         push_item_o
);
  import twa_pkg::*;

  logic [TIME_W-1:0] window_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_q <= window_seconds_i;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // threshold = time - window, clamped at zero
  always_comb begin
    push_item_o.sample_time = sample_time_i;
    push_item_o.sample_rate = sample_rate_i;
    if (sample_time_i <= window_q) begin
      push_item_o.threshold = '0;
    end else begin
      push_item_o.threshold = sample_time_i - window_q;
    end
  end

endmodule

// ----- hdl/twa_queue.sv -----
// Two-entry queue between the front and the back.
module twa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  twa_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output twa_pkg::item_t pop_item_o
);
  import twa_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o     = (fill_q == 2'd2);
  assign empty_o    = (fill_q == 2'd0);
  assign pop_item_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// ----- hdl/twa_back.sv -----
// Back end: sample ring, expiry walk, serial divider and result register.
module twa_back #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  twa_pkg::item_t q_item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    window_average_o,
  output logic [6:0]     window_count_o,
  output logic [6:0]     expired_count_o,
  output logic           evicted_full_o
);
  import twa_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = AVG_W + CW;
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_DIV,
    S_OUT
  } state_e;

  state_e            state_q;
  logic [IW-1:0]     head_q;
  logic [IW-1:0]     tail_q;
  logic [CW-1:0]     count_q;
  logic [SW-1:0]     sum_q;
  logic [CW-1:0]     expired_q;
  logic              evicted_q;
  item_t             cur_q;
  logic [CW-1:0]     rem_q;
  logic [AVG_W-1:0]  quo_q;
  logic [CW-1:0]     divisor_q;
  logic [STEP_W-1:0] step_q;

  logic [TIME_W-1:0] time_mem [CAPACITY];
  logic [RATE_W-1:0] rate_mem [CAPACITY];
  logic [TIME_W-1:0] rd_time_q;
  logic [RATE_W-1:0] rd_rate_q;

  logic              mem_we;
  logic [SW-1:0]     sum_new;
  logic [CW-1:0]     count_new;
  logic [CW:0]       trial;
  logic [CW:0]       trial_diff;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
    next_slot = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
  endfunction

  assign pop_o  = (state_q == S_IDLE) && !q_empty_i;
  assign mem_we = (state_q == S_WRITE);

  // Ring store; read port always follows the head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      time_mem[tail_q] <= cur_q.sample_time;
      rate_mem[tail_q] <= cur_q.sample_rate;
    end
    rd_time_q <= time_mem[head_q];
    rd_rate_q <= rate_mem[head_q];
  end

  assign sum_new    = sum_q + SW'(cur_q.sample_rate);
  assign count_new  = count_q + 1'b1;
  assign trial      = {rem_q, quo_q[AVG_W-1]};
  assign trial_diff = trial - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      head_q           <= '0;
      tail_q           <= '0;
      count_q          <= '0;
      sum_q            <= '0;
      expired_q        <= '0;
      evicted_q        <= 1'b0;
      step_q           <= '0;
      out_valid_o      <= 1'b0;
      window_average_o <= '0;
      window_count_o   <= '0;
      expired_count_o  <= '0;
      evicted_full_o   <= 1'b0;
    end else begin
      // in S_OUT the output register is reloaded instead
      if (out_valid_o && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            cur_q     <= q_item_i;
            expired_q <= '0;
            evicted_q <= 1'b0;
            state_q   <= S_READ;
          end
        end
        S_READ: begin
          // head entry lands in the read register next cycle
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if ((count_q != '0) && (rd_time_q <= cur_q.threshold)) begin
            sum_q     <= sum_q - SW'(rd_rate_q);
            head_q    <= next_slot(head_q);
            count_q   <= count_q - 1'b1;
            expired_q <= expired_q + 1'b1;
            state_q   <= S_READ;
          end else if (count_q == FULL_CNT) begin
            sum_q     <= sum_q - SW'(rd_rate_q);
            head_q    <= next_slot(head_q);
            count_q   <= count_q - 1'b1;
            evicted_q <= 1'b1;
            state_q   <= S_WRITE;
          end else begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          tail_q    <= next_slot(tail_q);
          count_q   <= count_new;
          sum_q     <= sum_new;
          // mean fits in 32 bits, so the upper sum bits are below the count
          rem_q     <= sum_new[SW-1:AVG_W];
          quo_q     <= sum_new[AVG_W-1:0];
          divisor_q <= count_new;
          step_q    <= STEP_W'(DIV_STEPS - 1);
          state_q   <= S_DIV;
        end
        S_DIV: begin
          if (!trial_diff[CW]) begin
            rem_q <= trial_diff[CW-1:0];
            quo_q <= {quo_q[AVG_W-2:0], 1'b1};
          end else begin
            rem_q <= trial[CW-1:0];
            quo_q <= {quo_q[AVG_W-2:0], 1'b0};
          end
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o      <= 1'b1;
            window_average_o <= quo_q;
            window_count_o   <= OUT_CNT_W'(count_q);
            expired_count_o  <= OUT_CNT_W'(expired_q);
            evicted_full_o   <= evicted_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/time_window_average_fifo.sv -----
// Sliding time-window moving average over timestamped rate samples.
//
// Input channel: in_valid_i / in_stall_o with sample_time_i and sample_rate_i
// (Q16.16). Timestamps are expected nondecreasing. A transaction completes
// when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with the window mean, the count
// held, the number of entries expired and the full-eviction flag; one
// result per sample, in order.
// Config channel: window_seconds_i written on cfg_valid_i && cfg_ready_o;
// ready is always high. Write only while the block is idle.
// Processing: an accepted sample passes the queue, then the back end runs one
// read-and-test of the ring head for each entry it expires, writes the sample
// into the ring and derives the mean with a 32-step restoring divider before
// out_valid_o rises. The back end takes a new sample only once back in idle;
// a two-entry queue lets the front accept up to two more samples meanwhile.
// Reset: window returns to 300 s, the ring empties, no result is pending.
// A stalled result holds in the output register; the back end then waits
// with the next finished result until that register frees up.
module time_window_average_fifo #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_time_i,
  input  logic [31:0] sample_rate_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] window_average_o,
  output logic [6:0]  window_count_o,
  output logic [6:0]  expired_count_o,
  output logic        evicted_full_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] window_seconds_i
);
  import twa_pkg::*;

  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  item_t push_item;
  item_t pop_item;

  twa_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_time_i   (sample_time_i),
    .sample_rate_i   (sample_rate_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .window_seconds_i(window_seconds_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_item_o     (push_item)
  );

  twa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_item_o (pop_item)
  );

  twa_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_item_i        (pop_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .window_average_o(window_average_o),
    .window_count_o  (window_count_o),
    .expired_count_o (expired_count_o),
    .evicted_full_o  (evicted_full_o)
  );

endmodule

// ----- hdl/twa_checker.sv -----
// Port-level assertions for the time window average block, with its bind.
module twa_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] window_average_o,
  input logic [6:0]  window_count_o,
  input logic [6:0]  expired_count_o,
  input logic        evicted_full_o
);

  localparam logic [6:0] FULL_CNT = 7'(CAPACITY);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_average_o)
      && $stable(window_count_o) && $stable(expired_count_o)
      && $stable(evicted_full_o))
    else $error("result changed while stalled");

  // a result always includes the new sample
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_count_o != 7'd0)
    else $error("empty window reported");

  // eviction only happens when nothing expired and leaves the ring full
  a_evict_no_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_full_o |-> expired_count_o == 7'd0)
    else $error("eviction together with expiry");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_full_o |-> window_count_o == FULL_CNT)
    else $error("eviction without a full ring");

endmodule

bind time_window_average_fifo twa_checker #(.CAPACITY(CAPACITY)) u_twa_checker (.*);
